// ===== rtl/header_trailer_frame_receiver_assert.svh =====
// Assertion macros for the header and trailer frame receiver.
`ifndef HEADER_TRAILER_FRAME_RECEIVER_ASSERT_SVH
`define HEADER_TRAILER_FRAME_RECEIVER_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define HTFR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define HTFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/htfr_pkg.sv =====
// Shared types and constants for the header and trailer frame receiver.
package htfr_pkg;

    localparam int PAYLOAD_MAX_DEFAULT = 32;

    // Register reset values
    localparam logic [7:0] HEADER_FIRST_RST   = 8'h06;
    localparam logic [7:0] HEADER_SECOND_RST  = 8'h31;
    localparam logic [7:0] TRAILER_FIRST_RST  = 8'h06;
    localparam logic [7:0] TRAILER_SECOND_RST = 8'h04;
    localparam logic [5:0] PAYLOAD_LEN_RST    = 6'd32;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAILER_FIRST  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAILER_SECOND = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LEN    = 3'd4;

    // Request operation codes
    localparam logic OP_RX_BYTE = 1'b0;
    localparam logic OP_READ    = 1'b1;

    // Framing phase, one-hot
    typedef enum logic [4:0] {
        PH_HUNT = 5'b00001,
        PH_HDR2 = 5'b00010,
        PH_DATA = 5'b00100,
        PH_TRL1 = 5'b01000,
        PH_TRL2 = 5'b10000
    } phase_t;

    // Payload buffer write request from the framer
    typedef struct packed {
        logic       en;
        logic [5:0] count;
        logic [7:0] data;
    } store_wr_t;

    // One result as held in the output queue
    typedef struct packed {
        logic       frame_good;
        logic [7:0] read_data;
    } result_t;

endpackage

// ===== rtl/htfr_ram.sv =====
// Generic single write port RAM with registered read.
module htfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/htfr_sync.sv =====
// Frame synchroniser: configuration registers, framing phase and byte count.
module htfr_sync #(
    parameter int PAYLOAD_MAX = htfr_pkg::PAYLOAD_MAX_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [htfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data,
    input  logic                           accept,
    input  logic                           op,
    input  logic [7:0]                     rx_byte,
    output logic                           frame_good,
    output htfr_pkg::store_wr_t            store_wr
);

    localparam int PM_W = $clog2(PAYLOAD_MAX + 1);
    localparam int LW   = (PM_W > 6) ? PM_W : 6;
    localparam logic [LW-1:0] PMAX = LW'(PAYLOAD_MAX);

    logic [7:0] header_first_reg, header_second_reg;
    logic [7:0] trailer_first_reg, trailer_second_reg;
    logic [5:0] payload_len_reg;

    htfr_pkg::phase_t phase_reg, phase_next;
    logic [5:0]       count_reg, count_next;

    logic [LW-1:0] len_ext, eff_len, count_inc_ext, count_ext;
    logic [5:0]    count_inc;
    logic          byte_req;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_first_reg   <= htfr_pkg::HEADER_FIRST_RST;
            header_second_reg  <= htfr_pkg::HEADER_SECOND_RST;
            trailer_first_reg  <= htfr_pkg::TRAILER_FIRST_RST;
            trailer_second_reg <= htfr_pkg::TRAILER_SECOND_RST;
            payload_len_reg    <= htfr_pkg::PAYLOAD_LEN_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                htfr_pkg::CFG_HEADER_FIRST:   header_first_reg   <= cfg_data;
                htfr_pkg::CFG_HEADER_SECOND:  header_second_reg  <= cfg_data;
                htfr_pkg::CFG_TRAILER_FIRST:  trailer_first_reg  <= cfg_data;
                htfr_pkg::CFG_TRAILER_SECOND: trailer_second_reg <= cfg_data;
                htfr_pkg::CFG_PAYLOAD_LEN:    payload_len_reg    <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // Clamp the payload length to one at the bottom and the buffer size at the top
    always_comb begin
        len_ext = LW'(payload_len_reg);
        if (len_ext == '0) begin
            eff_len = LW'(1);
        end else if (len_ext > PMAX) begin
            eff_len = PMAX;
        end else begin
            eff_len = len_ext;
        end
    end

    assign byte_req      = accept && (op == htfr_pkg::OP_RX_BYTE);
    assign count_inc     = count_reg + 6'd1;
    assign count_inc_ext = LW'(count_inc);
    assign count_ext     = LW'(count_reg);

    // Advance the framing phase on each received byte
    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        frame_good = 1'b0;
        unique case (phase_reg)
            htfr_pkg::PH_HUNT: begin
                phase_next = (rx_byte == header_first_reg) ? htfr_pkg::PH_HDR2
                                                           : htfr_pkg::PH_HUNT;
            end
            htfr_pkg::PH_HDR2: begin
                if (rx_byte == header_second_reg) begin
                    phase_next = htfr_pkg::PH_DATA;
                    count_next = '0;
                end else begin
                    phase_next = htfr_pkg::PH_HUNT;
                end
            end
            htfr_pkg::PH_DATA: begin
                if (count_inc_ext >= eff_len) begin
                    count_next = '0;
                    phase_next = htfr_pkg::PH_TRL1;
                end else begin
                    count_next = count_inc;
                end
            end
            htfr_pkg::PH_TRL1: begin
                phase_next = (rx_byte == trailer_first_reg) ? htfr_pkg::PH_TRL2
                                                            : htfr_pkg::PH_HUNT;
            end
            htfr_pkg::PH_TRL2: begin
                frame_good = (rx_byte == trailer_second_reg);
                phase_next = htfr_pkg::PH_HUNT;
            end
            default: begin
                phase_next = htfr_pkg::PH_HUNT;
            end
        endcase
        if (!byte_req) begin
            frame_good = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= htfr_pkg::PH_HUNT;
            count_reg <= '0;
        end else if (byte_req) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    // Store payload bytes that fall inside the buffer
    assign store_wr.en    = byte_req && (phase_reg == htfr_pkg::PH_DATA) && (count_ext < PMAX);
    assign store_wr.count = count_reg;
    assign store_wr.data  = rx_byte;

endmodule

// ===== rtl/htfr_out_fifo.sv =====
// Two-entry result queue between the datapath and the result channel.
module htfr_out_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  htfr_pkg::result_t push_data,
    output logic              full,
    output logic              can_push,
    output logic              m_valid,
    input  logic              m_ready,
    output htfr_pkg::result_t head
);

    htfr_pkg::result_t slot_reg [2];
    htfr_pkg::result_t slot_next [2];
    logic [1:0]        count_reg, count_next;
    logic [1:0]        wr_pos;
    logic              pop;

    assign m_valid  = (count_reg != 2'd0);
    assign full     = (count_reg == 2'd2);
    assign pop      = m_valid && m_ready;
    assign can_push = !full || pop;
    assign head     = slot_reg[0];
    assign wr_pos   = count_reg - {1'b0, pop};

    // Shift on pop, then place the new result behind what remains
    always_comb begin
        slot_next[0] = slot_reg[0];
        slot_next[1] = slot_reg[1];
        if (pop) begin
            slot_next[0] = slot_reg[1];
        end
        if (push) begin
            slot_next[wr_pos[0]] = push_data;
        end
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        slot_reg[0] <= slot_next[0];
        slot_reg[1] <= slot_next[1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/header_trailer_frame_receiver.sv =====
// Header and trailer frame receiver: takes one request per cycle, a received
// byte or a buffer read, and returns one result per request. Bytes are framed
// by a two-byte header, payload_len payload bytes and a two-byte trailer;
// frame_good pulses on the byte that completes a frame with a good trailer.
// A request is accepted every cycle while the result side keeps up; its result
// passes through the payload RAM's registered read port and the read stage,
// then a two-entry result queue that lets requests keep flowing while a result
// waits. The buffer reads as zero after reset through one flag per entry, so
// no clearing pass is needed and the block is ready straight out of reset.
module header_trailer_frame_receiver #(
    parameter int PAYLOAD_MAX = htfr_pkg::PAYLOAD_MAX_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [htfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_op,
    input  logic [7:0]                     s_rx_byte,
    input  logic [4:0]                     s_read_index,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_frame_good,
    output logic [7:0]                     m_read_data
);

    `include "header_trailer_frame_receiver_assert.svh"

    localparam int AW   = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
    localparam int CW   = (AW + 1 > 5) ? AW + 1 : 5;
    localparam logic [CW-1:0] PMAX = CW'(PAYLOAD_MAX);

    logic                s_accept;
    logic                good;
    htfr_pkg::store_wr_t store_wr;

    logic [CW-1:0]          idx_ext;
    logic [AW-1:0]          rd_addr, wr_addr;
    logic                   rd_en;
    logic [7:0]             ram_rd_data;
    logic [PAYLOAD_MAX-1:0] written_reg;

    logic valid_a_reg, valid_a_next;
    logic good_a_reg;
    logic rd_ok_a_reg;

    logic              fifo_full, fifo_can_push, drain;
    htfr_pkg::result_t push_data, head;

    // Hold off new requests only while both the stage and the queue are full
    assign s_ready  = !(valid_a_reg && fifo_full);
    assign s_accept = s_valid && s_ready;

    htfr_sync #(
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_sync (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .accept     (s_accept),
        .op         (s_op),
        .rx_byte    (s_rx_byte),
        .frame_good (good),
        .store_wr   (store_wr)
    );

    // Buffer addressing
    assign idx_ext = CW'(s_read_index);
    assign rd_addr = AW'(idx_ext);
    assign wr_addr = AW'(store_wr.count);
    assign rd_en   = s_accept && (s_op == htfr_pkg::OP_READ) && (idx_ext < PMAX);

    htfr_ram #(
        .WIDTH (8),
        .DEPTH (PAYLOAD_MAX)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (store_wr.en),
        .wr_addr (wr_addr),
        .wr_data (store_wr.data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    // Mark entries written since reset; others read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
        end else if (store_wr.en) begin
            written_reg[wr_addr] <= 1'b1;
        end
    end

    // Read stage alongside the RAM output register
    assign drain = valid_a_reg && fifo_can_push;

    always_comb begin
        valid_a_next = valid_a_reg;
        if (s_accept) begin
            valid_a_next = 1'b1;
        end else if (drain) begin
            valid_a_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
        end else begin
            valid_a_reg <= valid_a_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            good_a_reg  <= good;
            rd_ok_a_reg <= rd_en && written_reg[rd_addr];
        end
    end

    assign push_data.frame_good = good_a_reg;
    assign push_data.read_data  = rd_ok_a_reg ? ram_rd_data : 8'd0;

    htfr_out_fifo u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (drain),
        .push_data (push_data),
        .full      (fifo_full),
        .can_push  (fifo_can_push),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .head      (head)
    );

    assign m_frame_good = head.frame_good;
    assign m_read_data  = head.read_data;

    // A read request never flags a good frame
    `HTFR_ASSERT_NEXT(a_read_no_good, aclk, aresetn, s_accept && s_op, valid_a_reg && !good_a_reg, "read request flagged frame_good")
    // A read request never writes the payload buffer
    `HTFR_ASSERT_SAME(a_read_no_write, aclk, aresetn, s_accept && s_op, !store_wr.en, "buffer written on a read request")
    // A blocked stage keeps its result
    `HTFR_ASSERT_NEXT(a_stage_holds, aclk, aresetn, valid_a_reg && !fifo_can_push, valid_a_reg, "read stage dropped a result")

endmodule
